// ----- hdl/id3fte_pkg.sv -----
// shared constants for the tag frame text extractor
package id3fte_pkg;

	// configuration port
	localparam int CFG_REGS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int ID_W = 32;

	// payload field widths
	localparam int BYTE_W = 8;
	localparam int TAG_W = 3;
	localparam int FIN_W = 2;
	localparam int POS_W = 4;
	localparam int LEN_W = 32;

	// parameter defaults
	localparam int HEADER_BYTES_DEF = 10;
	localparam int NUM_IDS_DEF = 6;
	localparam int MAX_IDS = 8;

	// frame header layout
	localparam logic [POS_W-1:0] ID_LAST_POS = POS_W'(3);
	localparam logic [POS_W-1:0] SIZE_LAST_POS = POS_W'(3);
	localparam logic [POS_W-1:0] FLAGS_LAST_POS = POS_W'(1);

	// wanted frame id values after reset
	localparam logic [ID_W-1:0] ID_RESET [CFG_REGS] = '{
		32'h5449_5432, // TIT2
		32'h5441_4C42, // TALB
		32'h5459_4552, // TYER
		32'h5443_4F4E, // TCON
		32'h434F_4D4D, // COMM
		32'h5450_4531  // TPE1
	};

	// text encoding codes
	localparam logic [BYTE_W-1:0] ENC_LATIN1 = 8'd0;
	localparam logic [BYTE_W-1:0] ENC_UTF16 = 8'd1;
	localparam logic [BYTE_W-1:0] ENC_UTF8 = 8'd3;

	// finish status codes
	localparam logic [FIN_W-1:0] FIN_RUN = 2'd0;
	localparam logic [FIN_W-1:0] FIN_OK = 2'd1;
	localparam logic [FIN_W-1:0] FIN_FAIL = 2'd2;

	// stream widths
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

endpackage

// ----- hdl/id3v2_frame_text_extractor_top.sv -----
// tag frame text extractor: parses a byte stream and streams text of wanted frames
//
// The block takes an audio file one byte per transaction on the slave stream, with
// tlast on the last byte of the file, skips the HEADER_BYTES file header and then
// walks the frames (4-byte id, 4-byte big-endian size, 2 flag bytes, payload). A
// frame whose id equals one of the NUM_IDS wanted ids (registers 0..5 of the
// configuration port, lowest slot wins) is announced with frame_start and its tag
// index, and its text characters follow one per transaction: encodings 0 and 3
// give the bytes after the encoding byte up to the first zero, encoding 1 gives
// the bytes at payload offsets 3, 5, 7 and so on. tlast on the master side marks
// the last payload byte of a wanted frame. finished reports success (1) or
// failure (2) once; after it the block drops bytes until the end of the file and
// then rearms. Bytes that produce nothing cause no master transaction. Throughput
// is one byte per clock cycle unless the output stalls, set by the single per-byte
// update of the parse state. A taken byte sits in the input register and its result
// is then offered from the result register. There is no clearing pass after reset.
// The user must write configuration only while idle; the block does not enforce it.
module id3v2_frame_text_extractor_top
	import id3fte_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int NUM_IDS = NUM_IDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [ID_W-1:0]       cfg_data,
	// file bytes in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] file_byte
	input  logic                  s_axis_tlast,  // end_of_file
	// results out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [2:0] tag_index, [10:3] char_value,
	                                             // [12:11] finished, [15:13] zero
	output logic [M_TUSER_W-1:0]  m_axis_tuser,  // [0] frame_start, [1] char_valid
	output logic                  m_axis_tlast   // frame_end
);

	localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ID,
		PH_SIZE,
		PH_FLAGS,
		PH_TEXT,
		PH_SKIP,
		PH_DONE
	} phase_t;

	// wanted id registers; slots without a register hold zero
	logic [ID_W-1:0] frame_id_q [NUM_IDS];

	for (genvar gi = 0; gi < NUM_IDS; gi++) begin : g_ids
		if (gi < CFG_REGS) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					frame_id_q[gi] <= ID_RESET[gi];
				end else if (cfg_we && cfg_index == CFG_IDX_W'(gi)) begin
					frame_id_q[gi] <= cfg_data;
				end
			end
		end else begin : g_zero
			assign frame_id_q[gi] = '0;
		end
	end

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eof_s1;

	// parse state
	phase_t            phase_q;
	logic [POS_W-1:0]  pos_q;
	logic [ID_W-1:0]   id_shift_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  offset_q;
	logic [BYTE_W-1:0] enc_q;
	logic              stopped_q;
	logic [TAG_W-1:0]  slot_q;

	// result register
	logic              out_valid_q;
	logic              fs_q;
	logic [TAG_W-1:0]  tag_q;
	logic              cv_q;
	logic [BYTE_W-1:0] cval_q;
	logic              fe_q;
	logic [FIN_W-1:0]  fin_q;

	// a byte moves out of the input register when the result slot is free or draining
	logic advance;
	logic in_take;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take = s_axis_tvalid && s_axis_tready;

	// id lookup, lowest slot wins
	logic             id_hit;
	logic [TAG_W-1:0] id_slot;

	always_comb begin
		id_hit = 1'b0;
		id_slot = '0;
		for (int i = NUM_IDS - 1; i >= 0; i--) begin
			if (frame_id_q[i] == id_shift_q) begin
				id_hit = 1'b1;
				id_slot = TAG_W'(i);
			end
		end
	end

	// next parse state and result for the byte in the input register
	phase_t            phase_n;
	logic [POS_W-1:0]  pos_n;
	logic [ID_W-1:0]   id_shift_n;
	logic [LEN_W-1:0]  length_n;
	logic [LEN_W-1:0]  offset_n;
	logic [BYTE_W-1:0] enc_n;
	logic              stopped_n;
	logic [TAG_W-1:0]  slot_n;
	logic              fs_n;
	logic              cv_n;
	logic [BYTE_W-1:0] cval_n;
	logic              fe_n;
	logic [FIN_W-1:0]  fin_n;
	logic              about_n;
	logic              has_result;

	always_comb begin
		logic [POS_W-1:0] pos_inc;
		logic [LEN_W-1:0] len_shift;
		logic             last_payload;

		phase_n = phase_q;
		pos_n = pos_q;
		id_shift_n = id_shift_q;
		length_n = length_q;
		offset_n = offset_q;
		enc_n = enc_q;
		stopped_n = stopped_q;
		slot_n = slot_q;
		fs_n = 1'b0;
		cv_n = 1'b0;
		cval_n = '0;
		fe_n = 1'b0;
		fin_n = FIN_RUN;
		about_n = 1'b0;

		pos_inc = pos_q + POS_W'(1);
		len_shift = {length_q[LEN_W-BYTE_W-1:0], byte_s1};
		last_payload = (offset_q + LEN_W'(1) == length_q) || (length_q == '0);

		unique case (phase_q)
			PH_HEADER: begin
				pos_n = pos_inc;
				if (pos_inc >= HDR_LAST) begin
					phase_n = PH_ID;
					pos_n = '0;
				end
				if (eof_s1) fin_n = FIN_OK;
			end
			PH_ID: begin
				if (pos_q == '0 && byte_s1 == '0) begin
					// zero id byte: padding, the tag is over
					fin_n = FIN_OK;
				end else begin
					id_shift_n = {id_shift_q[ID_W-BYTE_W-1:0], byte_s1};
					pos_n = pos_inc;
					if (pos_q == ID_LAST_POS) begin
						pos_n = '0;
						length_n = '0;
						phase_n = PH_SIZE;
					end
					if (eof_s1) fin_n = FIN_OK;
				end
			end
			PH_SIZE: begin
				length_n = len_shift;
				pos_n = pos_inc;
				if (pos_q == SIZE_LAST_POS) begin
					pos_n = '0;
					if (len_shift == '0) begin
						fin_n = FIN_FAIL;
					end else begin
						phase_n = PH_FLAGS;
						if (eof_s1) fin_n = id_hit ? FIN_FAIL : FIN_OK;
					end
				end else if (eof_s1) begin
					fin_n = FIN_FAIL;
				end
			end
			PH_FLAGS: begin
				pos_n = pos_inc;
				if (pos_q == FLAGS_LAST_POS) begin
					pos_n = '0;
					offset_n = '0;
					if (id_hit) begin
						slot_n = id_slot;
						stopped_n = 1'b0;
						enc_n = ENC_LATIN1;
						fs_n = 1'b1;
						about_n = 1'b1;
						phase_n = PH_TEXT;
					end else begin
						phase_n = PH_SKIP;
					end
				end
				if (eof_s1) fin_n = id_hit ? FIN_FAIL : FIN_OK;
			end
			PH_TEXT: begin
				about_n = 1'b1;
				if (offset_q == '0) begin
					enc_n = byte_s1;
				end else if (enc_q == ENC_LATIN1 || enc_q == ENC_UTF8) begin
					if (!stopped_q) begin
						if (byte_s1 == '0) begin
							stopped_n = 1'b1;
						end else begin
							cv_n = 1'b1;
							cval_n = byte_s1;
						end
					end
				end else if (enc_q == ENC_UTF16) begin
					// low byte of each code unit after the byte order mark
					if (offset_q >= LEN_W'(3) && offset_q[0]) begin
						cv_n = 1'b1;
						cval_n = byte_s1;
					end
				end
				if (last_payload) begin
					fe_n = 1'b1;
					phase_n = PH_ID;
					pos_n = '0;
					if (eof_s1) fin_n = FIN_OK;
				end else begin
					offset_n = offset_q + LEN_W'(1);
					if (eof_s1) fin_n = FIN_FAIL;
				end
			end
			PH_SKIP: begin
				if (last_payload) begin
					phase_n = PH_ID;
					pos_n = '0;
				end else begin
					offset_n = offset_q + LEN_W'(1);
				end
				if (eof_s1) fin_n = FIN_OK;
			end
			PH_DONE: begin
				// drop bytes until the end of the file
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		if (fin_n != FIN_RUN) phase_n = PH_DONE;

		// end of file rearms everything
		if (eof_s1) begin
			phase_n = PH_HEADER;
			pos_n = '0;
			id_shift_n = '0;
			length_n = '0;
			offset_n = '0;
			enc_n = '0;
			stopped_n = 1'b0;
			slot_n = '0;
		end

		has_result = fs_n || cv_n || fe_n || (fin_n != FIN_RUN);
	end

	// input register, parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1 <= '0;
			eof_s1 <= 1'b0;
			phase_q <= PH_HEADER;
			pos_q <= '0;
			id_shift_q <= '0;
			length_q <= '0;
			offset_q <= '0;
			enc_q <= '0;
			stopped_q <= 1'b0;
			slot_q <= '0;
			out_valid_q <= 1'b0;
			fs_q <= 1'b0;
			tag_q <= '0;
			cv_q <= 1'b0;
			cval_q <= '0;
			fe_q <= 1'b0;
			fin_q <= FIN_RUN;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				byte_s1 <= s_axis_tdata;
				eof_s1 <= s_axis_tlast;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				phase_q <= phase_n;
				pos_q <= pos_n;
				id_shift_q <= id_shift_n;
				length_q <= length_n;
				offset_q <= offset_n;
				enc_q <= enc_n;
				stopped_q <= stopped_n;
				slot_q <= slot_n;
				out_valid_q <= has_result;
				fs_q <= fs_n;
				tag_q <= about_n ? slot_n : '0;
				cv_q <= cv_n;
				cval_q <= cval_n;
				fe_q <= fe_n;
				fin_q <= fin_n;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(M_TDATA_W - TAG_W - BYTE_W - FIN_W){1'b0}}, fin_q, cval_q, tag_q};
	assign m_axis_tuser = {cv_q, fs_q};
	assign m_axis_tlast = fe_q;

	// a finished code is never the unused value
	a_fin_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (fin_q == FIN_RUN || fin_q == FIN_OK || fin_q == FIN_FAIL))
		else $error("finished carries an unused code");

	// a frame announcement never carries a character
	a_start_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fs_q) |-> (!cv_q && !fe_q && fin_q != FIN_OK))
		else $error("frame start mixed with text or end");

	// the announced slot is one of the configured ids
	a_tag_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fs_q) |-> (32'(tag_q) < 32'(NUM_IDS)))
		else $error("tag index beyond the id table");

	// the last byte of a file always rearms the parser
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eof_s1) |=> (phase_q == PH_HEADER && pos_q == '0))
		else $error("parser not rearmed after end of file");

endmodule
